[sv/edit_distance_engine_macros.svh]
// Assertion macros for the edit distance engine.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef EDIT_DISTANCE_ENGINE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define EDT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define EDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define EDT_ASSERT_SAME(label, clk, rst, ante, cons, msg)

`define EDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[sv/edt_pkg.sv]
`default_nettype none

package edt_pkg;

   localparam int MAX_LEN_DEF = 64;

   localparam int OP_W        = 2;
   localparam int SYM_W       = 8;
   localparam int DIST_W      = 7;
   localparam int RSP_DATA_W  = 8;

   localparam logic [OP_W-1:0] OP_FIRST   = 2'd0;
   localparam logic [OP_W-1:0] OP_SECOND  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_first;
      logic load_second;
      logic start;
      logic init_step;
      logic row_start;
      logic cell_read;
      logic cell_write;
      logic finish;
   } edt_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic empty;
      logic col_end;
      logic row_end;
      logic out_free;
   } edt_status_type;

endpackage

`default_nettype wire

[sv/edit_distance_engine.sv]
// Edit distance engine: Levenshtein distance between two byte strings with
// unit costs for insert, delete and substitute.
// Requests arrive on the req_ channel. The opcode in req_tuser appends the
// byte in req_tdata to the first or the second string, or asks for the
// distance. Bytes beyond MAX_LEN per string are dropped and remembered.
// A compute request yields one result on the rsp_ channel: the distance in
// rsp_tdata (saturated at 127) and a truncation flag in rsp_tuser. Both
// strings and the flag are then cleared. An unused opcode is ignored.
// An append leaves the block in its idle state, so it stays ready. A
// compute request first seeds the single-ported row memory one row
// entry at a time, then does a read and then a write for each cell of
// the table. When either string is empty it goes straight to the result.
// The result sits in an output register; if the receiver stalls, the
// engine keeps accepting appends and waits only when the next result
// is ready to leave. Reset clears both lengths, the truncation flag and
// the output valid; string and row memories are not cleared.

`default_nettype none

`include "edit_distance_engine_macros.svh"

module edit_distance_engine
   import edt_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [SYM_W-1:0]      req_tdata,   // [7:0] symbol
   input  wire logic [OP_W-1:0]       req_tuser,   // [1:0] opcode
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [6:0] distance, [7] zero
   output logic                       rsp_tuser    // [0] truncated
);

   edt_cmd_type    cmd;
   edt_status_type status;

   // The controller sequences seeding, rows and cells of the table.
   edt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the strings, the cost row and the result register.
   edt_dpath #(
      .MAX_LEN (MAX_LEN)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A compute request always keeps the engine busy for the next cycle.
   `EDT_ASSERT_NEXT(a_compute_busy, clock, reset, req_tvalid && req_tready && req_tuser == OP_COMPUTE, !req_tready, "engine ready right after a compute request")

   // An append never takes the engine out of the ready state.
   `EDT_ASSERT_NEXT(a_append_ready, clock, reset, req_tvalid && req_tready && (req_tuser == OP_FIRST || req_tuser == OP_SECOND), req_tready, "engine not ready after an append")

   // A distance never exceeds the longest string the engine can hold.
   `EDT_ASSERT_SAME(a_dist_range, clock, reset, rsp_tvalid, 32'(rsp_tdata) <= MAX_LEN, "distance beyond string capacity")

endmodule

`default_nettype wire

[sv/edt_ctrl.sv]
`default_nettype none

module edt_ctrl
   import edt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   input  wire logic [OP_W-1:0] req_tuser,
   output logic                req_tready,
   input  wire edt_status_type status,
   output edt_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_INIT = 3'd1;
   localparam logic [2:0] ST_ROW  = 3'd2;
   localparam logic [2:0] ST_CRD  = 3'd3;
   localparam logic [2:0] ST_CWR  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  OP_FIRST:  cmd.load_first  = 1'b1;
                  OP_SECOND: cmd.load_second = 1'b1;
                  OP_COMPUTE: begin
                     cmd.start = 1'b1;
                     state_in  = status.empty ? ST_FIN : ST_INIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (status.row_end) begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            cmd.row_start = 1'b1;
            state_in      = ST_CRD;
         end
         ST_CRD: begin
            cmd.cell_read = 1'b1;
            state_in      = ST_CWR;
         end
         ST_CWR: begin
            cmd.cell_write = 1'b1;
            if (status.row_end) begin
               state_in = status.col_end ? ST_FIN : ST_ROW;
            end else begin
               state_in = ST_CRD;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[sv/edt_dpath.sv]
`default_nettype none

module edt_dpath
   import edt_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [SYM_W-1:0]      req_tdata,
   input  wire edt_cmd_type           cmd,
   output edt_status_type             status,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW    = (LEN_W > DIST_W) ? LEN_W : DIST_W;

   // String and row stores.
   logic [SYM_W-1:0] first_text_ff  [MAX_LEN];
   logic [SYM_W-1:0] second_text_ff [MAX_LEN];
   logic [LEN_W-1:0] row_costs_ff   [MAX_LEN+1];

   logic [SYM_W-1:0] first_q_ff;
   logic [SYM_W-1:0] second_q_ff;
   logic [LEN_W-1:0] row_q_ff;

   logic [LEN_W-1:0] len1_ff, len1_in;
   logic [LEN_W-1:0] len2_ff, len2_in;
   logic             ovf_ff,  ovf_in;
   logic [LEN_W-1:0] i_ff,    i_in;
   logic [LEN_W-1:0] j_ff,    j_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [LEN_W-1:0] diag_ff, diag_in;
   logic             valid_ff, valid_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic             trunc_ff, trunc_in;

   logic             first_full, second_full;
   logic             first_we, second_we;
   logic             row_we;
   logic [LEN_W-1:0] row_wa;
   logic [LEN_W-1:0] row_wd;

   logic [LEN_W:0]   above_p1, left_p1, sub_cost, min_ab, min_all;
   logic [LEN_W-1:0] cell_cost;
   logic [CW-1:0]    wide_dist;
   logic [DIST_W-1:0] sat_dist;

   assign first_full  = (len1_ff == LEN_W'(MAX_LEN));
   assign second_full = (len2_ff == LEN_W'(MAX_LEN));
   assign first_we    = cmd.load_first  && !first_full;
   assign second_we   = cmd.load_second && !second_full;

   // One cell of the recurrence: minimum of delete, insert and substitute.
   assign above_p1  = {1'b0, row_q_ff} + 1'b1;
   assign left_p1   = {1'b0, left_ff} + 1'b1;
   assign sub_cost  = {1'b0, diag_ff} + {{LEN_W{1'b0}}, (first_q_ff != second_q_ff)};
   assign min_ab    = (above_p1 < left_p1) ? above_p1 : left_p1;
   assign min_all   = (min_ab < sub_cost) ? min_ab : sub_cost;
   assign cell_cost = min_all[LEN_W-1:0];

   assign wide_dist = CW'(left_ff);
   assign sat_dist  = (wide_dist > CW'(DIST_MAX)) ? DIST_MAX : wide_dist[DIST_W-1:0];

   assign status.empty    = (len1_ff == '0) || (len2_ff == '0);
   assign status.row_end  = (j_ff == len2_ff);
   assign status.col_end  = (i_ff == len1_ff);
   assign status.out_free = !valid_ff || rsp_tready;

   always_comb begin
      len1_in  = len1_ff;
      len2_in  = len2_ff;
      ovf_in   = ovf_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      left_in  = left_ff;
      diag_in  = diag_ff;
      valid_in = valid_ff;
      dist_in  = dist_ff;
      trunc_in = trunc_ff;
      row_we   = 1'b0;
      row_wa   = '0;
      row_wd   = '0;

      if (cmd.load_first) begin
         if (first_full) begin
            ovf_in = 1'b1;
         end else begin
            len1_in = len1_ff + 1'b1;
         end
      end
      if (cmd.load_second) begin
         if (second_full) begin
            ovf_in = 1'b1;
         end else begin
            len2_in = len2_ff + 1'b1;
         end
      end
      if (cmd.start) begin
         i_in    = LEN_W'(1);
         j_in    = '0;
         left_in = (len1_ff == '0) ? len2_ff : len1_ff;
      end
      if (cmd.init_step) begin
         row_we = 1'b1;
         row_wa = j_ff;
         row_wd = j_ff;
         j_in   = j_ff + 1'b1;
      end
      if (cmd.row_start) begin
         row_we  = 1'b1;
         row_wa  = '0;
         row_wd  = i_ff;
         diag_in = i_ff - 1'b1;
         left_in = i_ff;
         j_in    = LEN_W'(1);
      end
      if (cmd.cell_write) begin
         row_we  = 1'b1;
         row_wa  = j_ff;
         row_wd  = cell_cost;
         left_in = cell_cost;
         diag_in = row_q_ff;
         if (j_ff == len2_ff) begin
            i_in = i_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.finish) begin
         valid_in = 1'b1;
         dist_in  = sat_dist;
         trunc_in = ovf_ff;
         len1_in  = '0;
         len2_in  = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (first_we) begin
         first_text_ff[len1_ff[AW-1:0]] <= req_tdata;
      end
      if (cmd.row_start) begin
         first_q_ff <= first_text_ff[AW'(i_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (second_we) begin
         second_text_ff[len2_ff[AW-1:0]] <= req_tdata;
      end
      if (cmd.cell_read) begin
         second_q_ff <= second_text_ff[AW'(j_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_costs_ff[row_wa] <= row_wd;
      end
      if (cmd.cell_read) begin
         row_q_ff <= row_costs_ff[j_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len1_ff  <= '0;
         len2_ff  <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         len1_ff  <= len1_in;
         len2_ff  <= len2_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      j_ff     <= j_in;
      left_ff  <= left_in;
      diag_ff  <= diag_in;
      dist_ff  <= dist_in;
      trunc_ff <= trunc_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(dist_ff);
   assign rsp_tuser  = trunc_ff;

endmodule

`default_nettype wire
